>>> rtl/core/wspr_pkg.sv
// Shared types, widths and codes for the wheel-speed PID regulator.
// Used by the channel interfaces and by every module under rtl/core.
// Has no dependencies of its own.
package wspr_pkg;

  // Width of the saturating integral accumulator.
  localparam int INTEGRAL_BITS = 48;

  // Fixed field widths.
  localparam int COUNT_W    = 32;
  localparam int SPEED_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int DIVISOR_W  = 15;
  localparam int DRIVE_W    = 16;
  localparam int SETPOINT_W = 16;
  localparam int MODE_W     = 2;
  localparam int CLAMP_W    = 2;

  // Datapath widths derived from the above.
  localparam int ERR_W  = SPEED_W + 1;
  localparam int PROD_W = GAIN_W + ERR_W;
  localparam int PD_W   = PROD_W + 1;
  localparam int ACC_W  = ((INTEGRAL_BITS > PD_W) ? INTEGRAL_BITS : PD_W) + 1;
  localparam int IU_W   = ((INTEGRAL_BITS > PROD_W) ? INTEGRAL_BITS : PROD_W) + 1;
  localparam int QUO_W  = 42;
  localparam int SUM_W  = QUO_W + 1;

  // Quotient is held within plus or minus this bound before the drive sum.
  localparam longint QUO_LIMIT = 64'sd1 <<< 40;

  // Radix-4 divider sizing.
  localparam int DIV_W     = ACC_W + (ACC_W % 2);
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Register port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register reset values.
  localparam logic signed [DRIVE_W-1:0]   DRIVE_MAX_RST = 16'sd255;
  localparam logic signed [DRIVE_W-1:0]   DRIVE_MIN_RST = -16'sd255;
  localparam logic        [DIVISOR_W-1:0] DIVISOR_RST   = 15'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 2'd0,
    MODE_CLEAR    = 2'd1,
    MODE_SETPOINT = 2'd2
  } mode_t;

  typedef enum logic [CLAMP_W-1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_MAX  = 2'd1,
    CLAMP_MIN  = 2'd2
  } clamp_t;

  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_GAIN_I    = 3'd3,
    REG_DIVISOR   = 3'd4,
    REG_DRIVE_MAX = 3'd5,
    REG_DRIVE_MIN = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_D = 2'd1,
    MUL_I = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic                        enable;
    logic signed [GAIN_W-1:0]    gain_p;
    logic signed [GAIN_W-1:0]    gain_d;
    logic signed [GAIN_W-1:0]    gain_i;
    logic        [DIVISOR_W-1:0] gain_divisor;
    logic signed [DRIVE_W-1:0]   drive_max;
    logic signed [DRIVE_W-1:0]   drive_min;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     clear;
    logic     load_sp;
    logic     diff;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_sub;
    logic     acc_int;
    logic     div_start;
    logic     quo_load;
    logic     clamp;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic speed_nz;
    logic div_last;
    logic out_free;
  } st_t;

endpackage

>>> rtl/core/wspr_req_if.sv
// Input channel of the regulator: valid/ready handshake with the tick payload.
// Depends on wspr_pkg for field widths.
interface wspr_req_if;
  import wspr_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [MODE_W-1:0]           mode;
  logic signed [COUNT_W-1:0]   enc_position;
  logic signed [SETPOINT_W-1:0] target_speed;

  modport source (output valid, mode, enc_position, target_speed, input ready);
  modport sink   (input valid, mode, enc_position, target_speed, output ready);
endinterface

>>> rtl/core/wspr_rsp_if.sv
// Output channel of the regulator: valid/ready handshake with the drive result.
// Depends on wspr_pkg for field widths.
interface wspr_rsp_if;
  import wspr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic [CLAMP_W-1:0]        clamp_state;

  modport source (output valid, drive, clamp_state, input ready);
  modport sink   (input valid, drive, clamp_state, output ready);
endinterface

>>> rtl/core/wspr_regs.sv
// APB-style configuration register file of the regulator.
// Depends on wspr_pkg for the register layout and reset values.
module wspr_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wspr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [wspr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [wspr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output wspr_pkg::cfg_t                   cfg
);
  import wspr_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b0;
      cfg.gain_p       <= '0;
      cfg.gain_d       <= '0;
      cfg.gain_i       <= '0;
      cfg.gain_divisor <= DIVISOR_RST;
      cfg.drive_max    <= DRIVE_MAX_RST;
      cfg.drive_min    <= DRIVE_MIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLE:    cfg.enable       <= pwdata[0];
        REG_GAIN_P:    cfg.gain_p       <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    cfg.gain_d       <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    cfg.gain_i       <= pwdata[GAIN_W-1:0];
        REG_DIVISOR:   cfg.gain_divisor <= pwdata[DIVISOR_W-1:0];
        REG_DRIVE_MAX: cfg.drive_max    <= pwdata[DRIVE_W-1:0];
        REG_DRIVE_MIN: cfg.drive_min    <= pwdata[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back; signed registers are sign-extended to the bus width.
  always_comb begin
    case (idx)
      REG_ENABLE:    prdata = APB_DATA_W'(cfg.enable);
      REG_GAIN_P:    prdata = APB_DATA_W'(cfg.gain_p);
      REG_GAIN_D:    prdata = APB_DATA_W'(cfg.gain_d);
      REG_GAIN_I:    prdata = APB_DATA_W'(cfg.gain_i);
      REG_DIVISOR:   prdata = APB_DATA_W'(cfg.gain_divisor);
      REG_DRIVE_MAX: prdata = APB_DATA_W'(cfg.drive_max);
      REG_DRIVE_MIN: prdata = APB_DATA_W'(cfg.drive_min);
      default:       prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/wspr_div.sv
// Radix-4 restoring divider for the signed PID numerator, two quotient bits a cycle.
// Depends on wspr_pkg for the operand widths and step count.
module wspr_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [wspr_pkg::ACC_W-1:0]    dividend,
  input  logic [wspr_pkg::DIVISOR_W-1:0]       divisor,
  output logic                                 last,
  output logic signed [wspr_pkg::ACC_W-1:0]    quotient
);
  import wspr_pkg::*;

  logic [DIV_W-1:0]     dq;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;

  logic [ACC_W-1:0]     mag;
  logic [DIVISOR_W:0]   t1, t2, r1, r2;
  logic                 ge1, ge2;

  assign mag = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);

  // Two dependent restoring steps on the narrow partial remainder.
  always_comb begin
    t1  = {rem, dq[DIV_W-1]};
    ge1 = t1 >= {1'b0, dvs};
    r1  = ge1 ? t1 - {1'b0, dvs} : t1;
    t2  = {r1[DIVISOR_W-1:0], dq[DIV_W-2]};
    ge2 = t2 >= {1'b0, dvs};
    r2  = ge2 ? t2 - {1'b0, dvs} : t2;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= DIV_W'(mag);
      rem <= '0;
      dvs <= (divisor == '0) ? DIVISOR_W'(1) : divisor;
      neg <= dividend[ACC_W-1];
    end else if (cnt != '0) begin
      dq  <= {dq[DIV_W-3:0], ge1, ge2};
      rem <= r2[DIVISOR_W-1:0];
    end
  end

  assign last     = (cnt == DIV_CNT_W'(1));
  assign quotient = neg ? -$signed(dq[ACC_W-1:0]) : $signed(dq[ACC_W-1:0]);

endmodule

>>> rtl/core/wspr_datapath.sv
// Datapath of the regulator: loop state, shared gain multiplier, divider,
// clamp and integral update, and the result register. Uses wspr_pkg and wspr_div.
module wspr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wspr_pkg::cfg_t                        cfg,
  input  wspr_pkg::cmd_t                        cmd,
  output wspr_pkg::st_t                         st,
  input  logic signed [wspr_pkg::COUNT_W-1:0]   enc_position,
  input  logic signed [wspr_pkg::SETPOINT_W-1:0] target_speed,
  input  logic                                  res_ready,
  output logic                                  res_valid,
  output logic signed [wspr_pkg::DRIVE_W-1:0]   res_drive,
  output logic [wspr_pkg::CLAMP_W-1:0]          res_clamp
);
  import wspr_pkg::*;

  // Loop state.
  logic signed [SETPOINT_W-1:0]    setpoint;
  logic signed [INTEGRAL_BITS-1:0] integral;
  logic signed [COUNT_W-1:0]       prev_count;
  logic signed [SPEED_W-1:0]       prev_speed;
  logic signed [DRIVE_W-1:0]       prev_drive;

  // Working registers of one tick.
  logic signed [COUNT_W-1:0] count_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [ERR_W-1:0]   dspd_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc;
  logic signed [QUO_W-1:0]   quo_q;

  logic signed [SPEED_W-1:0]       speed_w;
  logic signed [ERR_W-1:0]         err_w;
  logic signed [ERR_W-1:0]         dspd_w;
  logic signed [GAIN_W-1:0]        mul_a;
  logic signed [ERR_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]        mul_p;
  logic signed [ACC_W-1:0]         div_q;
  logic                            div_last;
  logic signed [ACC_W-1:0]         q_hi;
  logic signed [ACC_W-1:0]         q_clip;
  logic signed [SUM_W-1:0]         dsum;
  logic signed [DRIVE_W-1:0]       drive_w;
  clamp_t                          clamp_w;
  logic signed [IU_W-1:0]          isum;
  logic                            i_ovf;
  logic signed [INTEGRAL_BITS-1:0] isat;

  // Speed, error and change of speed.
  assign speed_w = count_q - prev_count;
  assign err_w   = ERR_W'(setpoint) - ERR_W'(speed_w);
  assign dspd_w  = ERR_W'(speed_w) - ERR_W'(prev_speed);

  // One multiplier shared by the three gain terms.
  always_comb begin
    case (cmd.mul_sel)
      MUL_P:   mul_a = cfg.gain_p;
      MUL_D:   mul_a = cfg.gain_d;
      MUL_I:   mul_a = cfg.gain_i;
      default: mul_a = '0;
    endcase
    mul_b = (cmd.mul_sel == MUL_D) ? dspd_q : err_q;
  end
  assign mul_p = mul_a * mul_b;

  // Numerator of the increment: P product loaded, D product subtracted, then the integral added.
  always_ff @(posedge clk) begin
    if (cmd.capture) count_q <= enc_position;
    if (cmd.diff) begin
      speed_q <= speed_w;
      err_q   <= err_w;
      dspd_q  <= dspd_w;
    end
    if (cmd.mul_en) prod_q <= mul_p;
    if (cmd.acc_load) begin
      acc <= ACC_W'(prod_q);
    end else if (cmd.acc_sub) begin
      acc <= acc - ACC_W'(prod_q);
    end else if (cmd.acc_int) begin
      acc <= acc + ACC_W'(integral);
    end
    if (cmd.quo_load) quo_q <= QUO_W'(q_clip);
  end

  wspr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc),
    .divisor  (cfg.gain_divisor),
    .last     (div_last),
    .quotient (div_q)
  );

  // Bound the quotient so the drive sum stays narrow.
  assign q_hi = ACC_W'(QUO_LIMIT);
  always_comb begin
    if (div_q > q_hi) begin
      q_clip = q_hi;
    end else if (div_q < -q_hi) begin
      q_clip = -q_hi;
    end else begin
      q_clip = div_q;
    end
  end

  // Drive sum and clamp; the upper limit is tested first.
  assign dsum = SUM_W'(quo_q) + SUM_W'(prev_drive);
  always_comb begin
    if (dsum >= SUM_W'(cfg.drive_max)) begin
      drive_w = cfg.drive_max;
      clamp_w = CLAMP_MAX;
    end else if (dsum <= SUM_W'(cfg.drive_min)) begin
      drive_w = cfg.drive_min;
      clamp_w = CLAMP_MIN;
    end else begin
      drive_w = dsum[DRIVE_W-1:0];
      clamp_w = CLAMP_NONE;
    end
  end

  // Integral update, saturating at its own width.
  assign isum  = IU_W'(integral) + IU_W'(prod_q);
  assign i_ovf = !((&isum[IU_W-1:INTEGRAL_BITS-1]) || !(|isum[IU_W-1:INTEGRAL_BITS-1]));
  assign isat  = isum[IU_W-1] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                              : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};

  // Loop state: clear, setpoint load and the end-of-tick update.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= '0;
      integral   <= '0;
      prev_count <= '0;
      prev_speed <= '0;
      prev_drive <= '0;
    end else if (cmd.clear) begin
      setpoint   <= '0;
      integral   <= '0;
      prev_count <= enc_position;
      prev_speed <= '0;
      prev_drive <= '0;
    end else if (cmd.load_sp) begin
      setpoint <= target_speed;
    end else if (cmd.clamp) begin
      prev_count <= count_q;
      prev_speed <= speed_q;
      prev_drive <= drive_w;
      if (clamp_w == CLAMP_NONE) begin
        integral <= i_ovf ? isat : INTEGRAL_BITS'(isum);
      end
    end
  end

  // Result register; holds until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.clamp) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      res_drive <= drive_w;
      res_clamp <= clamp_w;
    end
  end

  assign st.speed_nz = (prev_speed != '0);
  assign st.div_last = div_last;
  assign st.out_free = !res_valid || res_ready;

endmodule

>>> rtl/core/wspr_ctrl.sv
// Sequencing state machine of the regulator: decodes each transaction and
// steps the datapath through one control tick. Depends on wspr_pkg.
module wspr_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [wspr_pkg::MODE_W-1:0] req_mode,
  input  logic                       cfg_enable,
  input  wspr_pkg::st_t              st,
  output logic                       req_ready,
  output wspr_pkg::cmd_t             cmd
);
  import wspr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DIFF   = 10'b00_0000_0010,
    S_MUL_P  = 10'b00_0000_0100,
    S_MUL_D  = 10'b00_0000_1000,
    S_MUL_I  = 10'b00_0001_0000,
    S_SUM    = 10'b00_0010_0000,
    S_DIV_GO = 10'b00_0100_0000,
    S_DIV    = 10'b00_1000_0000,
    S_QUO    = 10'b01_0000_0000,
    S_CLAMP  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MUL_P;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode_t'(req_mode))
            MODE_TICK: begin
              if (cfg_enable) begin
                cmd.capture = 1'b1;
                state_next  = S_DIFF;
              end else if (st.speed_nz) begin
                cmd.clear = 1'b1;
              end
            end
            MODE_CLEAR:    cmd.clear   = 1'b1;
            MODE_SETPOINT: cmd.load_sp = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        state_next  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_D;
        cmd.acc_load = 1'b1;
        state_next   = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I;
        cmd.acc_sub = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.acc_int = 1'b1;
        state_next  = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (st.div_last) state_next = S_QUO;
      end
      S_QUO: begin
        cmd.quo_load = 1'b1;
        state_next   = S_CLAMP;
      end
      S_CLAMP: begin
        if (st.out_free) begin
          cmd.clamp  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The divider never finishes in the cycle right after it is started.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_GO) |=> !st.div_last)
    else $error("divider reported its last step too early");

  // The sequencer stays with the divider until its last step.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && !st.div_last |=> (state == S_DIV))
    else $error("left the divide state before the quotient was complete");

  // The quotient is taken only right after the final divider step.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_QUO) |-> $past(st.div_last))
    else $error("quotient taken without a completed division");

endmodule

>>> rtl/core/wheel_speed_pid_regulator.sv
// Top level of the wheel-speed PID regulator: channels, register port and
// the controller, datapath and register file. Uses wspr_pkg and both channel interfaces.
//
//   Channel    Kind          Carries
//   request    valid/ready   mode, enc_position, target_speed
//   response   valid/ready   drive, clamp_state
//   APB port   psel/penable  enable, gain, divisor and limit registers at 4*index
//
// An enabled control tick steps through the capture, difference, multiply, sum, divide,
// quotient and clamp states; the radix-4 divider yields two quotient bits a cycle.
// Clear, setpoint load, disabled ticks and the unused mode complete without leaving the idle state.
// Reset is synchronous and leaves registers at their defaults and the loop state zero.
// A finished result waits in the output register; a new transaction is taken
// meanwhile, and a tick stalls at its clamp step only while that register is full.
module wheel_speed_pid_regulator (
  input  logic                            clk,
  input  logic                            rst,
  wspr_req_if.sink                        request,
  wspr_rsp_if.source                      response,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wspr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wspr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wspr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import wspr_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  st_t  st;
  logic req_ready;

  // Configuration registers.
  wspr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  wspr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (request.valid),
    .req_mode   (request.mode),
    .cfg_enable (cfg.enable),
    .st         (st),
    .req_ready  (req_ready),
    .cmd        (cmd)
  );

  assign request.ready = req_ready;

  // Arithmetic and loop state.
  wspr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .st           (st),
    .enc_position (request.enc_position),
    .target_speed (request.target_speed),
    .res_ready    (response.ready),
    .res_valid    (response.valid),
    .res_drive    (response.drive),
    .res_clamp    (response.clamp_state)
  );

endmodule

>>> bench/tb.sv
// Self-checking testbench for wheel_speed_pid_regulator: drives request transactions and
// register writes, predicts every drive result in-bench and compares each response.
// Depends on wspr_pkg, wspr_req_if, wspr_rsp_if and the regulator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wspr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 50;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 600;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    clamp_t                    clamp;
  } drive_result_t;

  typedef struct {
    logic                        enable;
    logic signed [GAIN_W-1:0]    kp;
    logic signed [GAIN_W-1:0]    kd;
    logic signed [GAIN_W-1:0]    ki;
    logic        [DIVISOR_W-1:0] divisor;
    logic signed [DRIVE_W-1:0]   drive_max;
    logic signed [DRIVE_W-1:0]   drive_min;
  } loop_cfg_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  wspr_req_if request_ch ();
  wspr_rsp_if response_ch ();

  wheel_speed_pid_regulator DUT (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Regulator copy held by the bench: configuration and loop state.
  loop_cfg_t                  cfg_m;
  logic signed [SETPOINT_W-1:0] sp_m;
  longint                     integ_m;
  logic signed [COUNT_W-1:0]  prev_count_m;
  logic signed [SPEED_W-1:0]  prev_speed_m;
  logic signed [DRIVE_W-1:0]  prev_drive_m;

  drive_result_t drive_q[$];
  drive_result_t got_m;

  int errors;
  int accepted;
  int ticks_sent;
  int results_checked;
  int config_writes;
  int cycle_count;
  int src_max_gap;
  int snk_max_gap;
  int hold_left;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, drive_q.size());
      $display("wheel_speed_pid_regulator test failed");
      $finish;
    end
  end

  task automatic note_error(string what, longint want, longint got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  function automatic int reg_bits(reg_idx_t idx);
    case (idx)
      REG_ENABLE:  return 1;
      REG_DIVISOR: return DIVISOR_W;
      default:     return GAIN_W;
    endcase
  endfunction

  task automatic clear_loop(logic signed [COUNT_W-1:0] count);
    sp_m         = '0;
    integ_m      = 0;
    prev_count_m = count;
    prev_speed_m = '0;
    prev_drive_m = '0;
  endtask

  // Works out the effect of one accepted transaction and queues any drive result.
  task automatic advance_regulator(logic [MODE_W-1:0] mode, logic signed [COUNT_W-1:0] count,
                                   logic signed [SETPOINT_W-1:0] target);
    logic signed [SPEED_W-1:0] speed;
    longint err, num, quo, sum, inc, div, imax, imin;
    drive_result_t r;
    imax = (64'sd1 <<< (INTEGRAL_BITS - 1)) - 1;
    imin = -imax - 1;
    case (mode)
      MODE_CLEAR:    clear_loop(count);
      MODE_SETPOINT: sp_m = target;
      MODE_TICK: begin
        if (!cfg_m.enable) begin
          // A disabled tick only restarts the loop when the wheel was seen moving.
          if (prev_speed_m != 0) clear_loop(count);
        end else begin
          ticks_sent++;
          speed = count - prev_count_m;
          err = longint'(sp_m) - longint'(speed);
          num = longint'(cfg_m.kp) * err
              - longint'(cfg_m.kd) * (longint'(speed) - longint'(prev_speed_m))
              + integ_m;
          div = (cfg_m.divisor == 0) ? 64'sd1 : longint'({1'b0, cfg_m.divisor});
          quo = num / div;
          if (quo > QUO_LIMIT) quo = QUO_LIMIT;
          if (quo < -QUO_LIMIT) quo = -QUO_LIMIT;
          sum = quo + longint'(prev_drive_m);
          // The upper limit is tested first, which matters when the limits cross.
          if (sum >= longint'(cfg_m.drive_max)) begin
            sum = cfg_m.drive_max;
            r.clamp = CLAMP_MAX;
          end else if (sum <= longint'(cfg_m.drive_min)) begin
            sum = cfg_m.drive_min;
            r.clamp = CLAMP_MIN;
          end else begin
            r.clamp = CLAMP_NONE;
            inc = longint'(cfg_m.ki) * err;
            if (inc > 0 && integ_m > imax - inc) integ_m = imax;
            else if (inc < 0 && integ_m < imin - inc) integ_m = imin;
            else integ_m = integ_m + inc;
          end
          prev_count_m = count;
          prev_speed_m = speed;
          prev_drive_m = sum[DRIVE_W-1:0];
          r.drive = sum[DRIVE_W-1:0];
          drive_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Sends one request transaction after a random gap; returns at the falling edge.
  task automatic send_item(logic [MODE_W-1:0] mode, logic signed [COUNT_W-1:0] count,
                           logic signed [SETPOINT_W-1:0] target);
    int gap;
    gap = $urandom_range(0, src_max_gap);
    repeat (gap) @(negedge clk);
    request_ch.valid        = 1'b1;
    request_ch.mode         = mode;
    request_ch.enc_position = count;
    request_ch.target_speed = target;
    do @(posedge clk); while (!request_ch.ready);
    advance_regulator(mode, count, target);
    accepted++;
    @(negedge clk);
    request_ch.valid = 1'b0;
  endtask

  // Register write over the APB port, sometimes with junk above the register width.
  task automatic write_register(reg_idx_t idx, logic [31:0] value);
    logic [31:0] mask, data;
    mask = (32'd1 << reg_bits(idx)) - 1;
    data = value & mask;
    if ($urandom_range(0, 1)) data = data | ($urandom() & ~mask);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ENABLE:    cfg_m.enable    = data[0];
      REG_GAIN_P:    cfg_m.kp        = data[GAIN_W-1:0];
      REG_GAIN_D:    cfg_m.kd        = data[GAIN_W-1:0];
      REG_GAIN_I:    cfg_m.ki        = data[GAIN_W-1:0];
      REG_DIVISOR:   cfg_m.divisor   = data[DIVISOR_W-1:0];
      REG_DRIVE_MAX: cfg_m.drive_max = data[DRIVE_W-1:0];
      REG_DRIVE_MIN: cfg_m.drive_min = data[DRIVE_W-1:0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Register read; only the bits within the register width are compared.
  task automatic check_register(reg_idx_t idx);
    logic [31:0] mask, want;
    mask = (32'd1 << reg_bits(idx)) - 1;
    case (idx)
      REG_ENABLE:    want = {31'd0, cfg_m.enable};
      REG_GAIN_P:    want = 32'(cfg_m.kp);
      REG_GAIN_D:    want = 32'(cfg_m.kd);
      REG_GAIN_I:    want = 32'(cfg_m.ki);
      REG_DIVISOR:   want = 32'(cfg_m.divisor);
      REG_DRIVE_MAX: want = 32'(cfg_m.drive_max);
      default:       want = 32'(cfg_m.drive_min);
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (((prdata ^ want) & mask) != 0)
      note_error($sformatf("register %0d read", idx), want & mask, prdata & mask);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic wait_drain();
    while (drive_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only with the block idle; a trailing no-result item may still be busy.
  task automatic wait_idle();
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return GAIN_W'($urandom());
      1:       return 16'sh7FFF;
      2:       return 16'sh8000;
      3:       return GAIN_W'($urandom_range(0, 16));
      default: return GAIN_W'(int'($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  task automatic apply_random_settings();
    int dmax, dmin;
    wait_idle();
    write_register(REG_ENABLE, 32'($urandom_range(0, 9) != 0));
    write_register(REG_GAIN_P, 32'(pick_gain()));
    write_register(REG_GAIN_D, 32'(pick_gain()));
    write_register(REG_GAIN_I, 32'(pick_gain()));
    case ($urandom_range(0, 9))
      0:       write_register(REG_DIVISOR, 0);
      1:       write_register(REG_DIVISOR, 1);
      2:       write_register(REG_DIVISOR, 32767);
      3, 4:    write_register(REG_DIVISOR, $urandom_range(1, 32767));
      default: write_register(REG_DIVISOR, $urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 19))
      0, 1: begin
        dmax = 32767;
        dmin = -32768;
      end
      2, 3: begin
        dmax = -int'($urandom_range(0, 300));
        dmin = $urandom_range(0, 300);
      end
      4: begin
        dmax = $urandom();
        dmin = $urandom();
      end
      default: begin
        dmax = $urandom_range(20, 2000);
        dmin = -int'($urandom_range(20, 2000));
      end
    endcase
    write_register(REG_DRIVE_MAX, dmax);
    write_register(REG_DRIVE_MIN, dmin);
  endtask

  // Mostly well-formed runs: a clear, a setpoint, then ticks whose counts advance
  // near the setpoint speed, mixed with random counts, reloads and unused modes.
  task automatic run_random_phase(int n_items, int max_gap);
    logic signed [COUNT_W-1:0] wheel_pos;
    int k, r, delta;
    apply_random_settings();
    src_max_gap = (max_gap >= 0) ? max_gap : ($urandom_range(0, 2) == 0 ? 0 : 11);
    snk_max_gap = (max_gap >= 0) ? max_gap : ($urandom_range(0, 2) == 0 ? 3 : 11);
    wheel_pos = $urandom();
    if ($urandom_range(0, 9) < 7) begin
      send_item(MODE_CLEAR, wheel_pos, SETPOINT_W'($urandom()));
      send_item(MODE_SETPOINT, $urandom(), SETPOINT_W'(int'($urandom_range(0, 80)) - 40));
    end
    k = 0;
    while (k < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        wheel_pos = $urandom();
        send_item(MODE_CLEAR, wheel_pos, SETPOINT_W'($urandom()));
      end else if (r < 8) begin
        send_item(MODE_SETPOINT, $urandom(),
                  SETPOINT_W'((r < 6) ? int'($urandom_range(0, 80)) - 40 : int'($urandom())));
      end else if (r < 11) begin
        send_item(MODE_UNUSED, $urandom(), SETPOINT_W'($urandom()));
      end else if (r < 15) begin
        send_item(MODE_TICK, $urandom(), SETPOINT_W'($urandom()));
      end else begin
        delta = int'(sp_m) + int'($urandom_range(0, 6)) - 3;
        if (r > 90) delta = delta + int'($urandom_range(0, 400)) - 200;
        wheel_pos = wheel_pos + delta;
        send_item(MODE_TICK, wheel_pos, SETPOINT_W'($urandom()));
      end
      if (r < 8 || r >= 11) k++;
    end
  endtask

  // Response checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && response_ch.valid && response_ch.ready) begin
      results_checked++;
      if (drive_q.size() == 0) begin
        note_error("drive result with nothing expected", 0, response_ch.drive);
      end else begin
        got_m = drive_q.pop_front();
        if (response_ch.drive !== got_m.drive)
          note_error("drive mismatch", got_m.drive, response_ch.drive);
        if (response_ch.clamp_state !== got_m.clamp)
          note_error("clamp_state mismatch", got_m.clamp, response_ch.clamp_state);
      end
    end
  end

  // Response receiver: a random stall per result, plus any long hold-off requested.
  initial begin
    response_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (response_ch.valid && response_ch.ready)
        stall_left = $urandom_range(0, snk_max_gap);
      @(negedge clk);
      if (hold_left > 0) begin
        response_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        response_ch.ready = 1'b0;
        stall_left--;
      end else begin
        response_ch.ready = 1'b1;
      end
    end
  end

  // Every register at its extremes, with junk above the width, then read back.
  task automatic test_register_access();
    for (int i = 0; i <= REG_DRIVE_MIN; i++) begin
      write_register(reg_idx_t'(i), 32'hFFFF_FFFF);
      check_register(reg_idx_t'(i));
      write_register(reg_idx_t'(i), (reg_idx_t'(i) == REG_DIVISOR) ? 32'd1 : 32'h0000_8000);
      check_register(reg_idx_t'(i));
      write_register(reg_idx_t'(i), 32'h0000_7FFF);
      check_register(reg_idx_t'(i));
    end
  endtask

  // Field extremes, every mode and the corner cases of the loop.
  task automatic test_directed_cases();
    src_max_gap = 2;
    snk_max_gap = 2;
    wait_idle();
    write_register(REG_ENABLE, 1);
    write_register(REG_GAIN_P, 32'h7FFF);
    write_register(REG_GAIN_D, 32'hFFFF_8000);
    write_register(REG_GAIN_I, 32'h7FFF);
    write_register(REG_DIVISOR, 1);
    write_register(REG_DRIVE_MAX, 32'h7FFF);
    write_register(REG_DRIVE_MIN, 32'hFFFF_8000);
    // Counts at both extremes, so the speed wraps at 32 bits.
    send_item(MODE_CLEAR, 32'sh8000_0000, 16'sh7FFF);
    send_item(MODE_SETPOINT, 32'sh7FFF_FFFF, 16'sh7FFF);
    send_item(MODE_TICK, 32'sh7FFF_FFFF, 16'sh8000);
    send_item(MODE_TICK, 32'sh8000_0000, 16'sh0000);
    send_item(MODE_SETPOINT, 32'sh0000_0000, 16'sh8000);
    send_item(MODE_TICK, 32'sh0000_0000, 16'shFFFF);
    send_item(MODE_UNUSED, 32'shFFFF_FFFF, 16'shFFFF);
    send_item(MODE_TICK, 32'sh7FFF_FFFF, 16'sh0000);
    // A divisor of zero behaves as one.
    wait_idle();
    write_register(REG_DIVISOR, 0);
    send_item(MODE_TICK, 32'sd5, 16'sd0);
    send_item(MODE_TICK, 32'sd100, 16'sd0);
    // Crossed limits: the upper test wins.
    wait_idle();
    write_register(REG_GAIN_P, 3);
    write_register(REG_GAIN_D, 1);
    write_register(REG_GAIN_I, 1);
    write_register(REG_DRIVE_MAX, -100);
    write_register(REG_DRIVE_MIN, 100);
    send_item(MODE_CLEAR, 32'sd0, 16'sd0);
    send_item(MODE_SETPOINT, 32'sd0, 16'sd20);
    send_item(MODE_TICK, 32'sd10, 16'sd0);
    send_item(MODE_TICK, 32'sd30, 16'sd0);
    // Disabled ticks: the first restarts the loop (wheel moving), the second does nothing.
    wait_idle();
    write_register(REG_ENABLE, 0);
    send_item(MODE_TICK, 32'sd40, 16'sd0);
    send_item(MODE_TICK, 32'sd41, 16'sd0);
    send_item(MODE_SETPOINT, 32'sd0, 16'sd7);
    wait_idle();
    write_register(REG_ENABLE, 1);
    write_register(REG_DRIVE_MAX, 255);
    write_register(REG_DRIVE_MIN, -255);
    send_item(MODE_TICK, 32'sd50, 16'sd0);
    send_item(MODE_TICK, 32'sd58, 16'sd0);
  endtask

  // Long receiver hold-off while ticks keep coming, then a full drain before resuming.
  task automatic test_backpressure();
    logic signed [COUNT_W-1:0] wheel_pos;
    wait_idle();
    write_register(REG_ENABLE, 1);
    write_register(REG_GAIN_P, 40);
    write_register(REG_GAIN_D, 10);
    write_register(REG_GAIN_I, 2);
    write_register(REG_DIVISOR, 16);
    write_register(REG_DRIVE_MAX, 1000);
    write_register(REG_DRIVE_MIN, -1000);
    wheel_pos = $urandom();
    send_item(MODE_CLEAR, wheel_pos, SETPOINT_W'($urandom()));
    send_item(MODE_SETPOINT, $urandom(), 16'sd25);
    src_max_gap = 0;
    snk_max_gap = 0;
    hold_left   = LONG_HOLD;
    repeat (30) begin
      wheel_pos = wheel_pos + 22 + int'($urandom_range(0, 6));
      send_item(MODE_TICK, wheel_pos, SETPOINT_W'($urandom()));
    end
    wait_drain();
    src_max_gap = 11;
    snk_max_gap = 11;
    repeat (20) begin
      wheel_pos = wheel_pos + 22 + int'($urandom_range(0, 6));
      send_item(MODE_TICK, wheel_pos, SETPOINT_W'($urandom()));
    end
  endtask

  task automatic test_random_operation();
    for (int p = 0; p < 13; p++)
      run_random_phase(95, (p == 4) ? 0 : -1);
  endtask

  initial begin
    rst                     = 1'b1;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    request_ch.valid        = 1'b0;
    request_ch.mode         = MODE_TICK;
    request_ch.enc_position = '0;
    request_ch.target_speed = '0;
    src_max_gap = 0;
    snk_max_gap = 0;
    hold_left   = 0;
    stall_left  = 0;
    cfg_m.enable    = 1'b0;
    cfg_m.kp        = '0;
    cfg_m.kd        = '0;
    cfg_m.ki        = '0;
    cfg_m.divisor   = DIVISOR_RST;
    cfg_m.drive_max = DRIVE_MAX_RST;
    cfg_m.drive_min = DRIVE_MIN_RST;
    clear_loop('0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_access();
    test_directed_cases();
    test_backpressure();
    test_random_operation();

    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d accepted transactions, %0d enabled control ticks and %0d register writes",
             accepted, ticks_sent, config_writes);
    $display("across mixed gain, divisor and limit settings; %0d drive results checked.",
             results_checked);
    if (errors == 0) begin
      $display("wheel_speed_pid_regulator test passed");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("wheel_speed_pid_regulator test failed");
    end
    $finish;
  end

endmodule
